// ----- hdl/nvs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nvs_pkg
// shared types, sizes and codes of the nearest vertex search block
// ----------------------------------------------------------------------------
package nvs_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int ADDR_W       = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

  localparam int COORD_W  = 16;
  localparam int ABS_W    = 16;
  localparam int SQ_W     = 2 * ABS_W;
  localparam int DIST_W   = 34;
  localparam int INDEX_W  = 10;
  localparam int STATUS_W = 2;
  localparam int ACTION_W = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD  = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_QUERY = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vertex_t;

  // control that travels alongside one vertex through the scan pipeline
  typedef struct packed {
    logic              vld;
    logic              last;
    logic [ADDR_W-1:0] idx;
  } scan_tag_t;

  // low bits of a store index, zero extended when the store is narrow
  function automatic logic [INDEX_W-1:0] to_index(input logic [ADDR_W-1:0] idx);
    logic [ADDR_W+INDEX_W-1:0] ext;
    ext = {{INDEX_W{1'b0}}, idx};
    return ext[INDEX_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- hdl/nvs_req_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nvs_req_if
// request channel: action and one point
// ----------------------------------------------------------------------------
interface nvs_req_if
  import nvs_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [ACTION_W-1:0]       action;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] coord_z;

  modport source (output valid, action, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, action, coord_x, coord_y, coord_z, output ready);
endinterface
`default_nettype wire

// ----- hdl/nvs_rsp_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nvs_rsp_if
// result channel: status and the closest vertex
// ----------------------------------------------------------------------------
interface nvs_rsp_if
  import nvs_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic [INDEX_W-1:0]        best_index;
  logic signed [COORD_W-1:0] best_x;
  logic signed [COORD_W-1:0] best_y;
  logic signed [COORD_W-1:0] best_z;
  logic [DIST_W-1:0]         best_dist_sq;

  modport source (output valid, status, best_index, best_x, best_y, best_z, best_dist_sq,
                  input ready);
  modport sink   (input valid, status, best_index, best_x, best_y, best_z, best_dist_sq,
                  output ready);
endinterface
`default_nettype wire

// ----- hdl/nearest_vertex_search.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_vertex_search
// brute-force nearest vertex search over a store of Q8.8 positions
// ----------------------------------------------------------------------------
//
//  port     dir  handshake      contents
//  in_req   in   valid/ready    action, coord_x, coord_y, coord_z
//  out_rsp  out  valid/ready    status, best_index, best_x/y/z, best_dist_sq
//
//  load, clear and unused codes: the result is registered at accept
//  query: the single read port of the vertex store feeds one vertex a cycle
//    into the distance pipeline
//  reset clears the vertex count, the control state and the valid flags only; the store needs
//    no clearing pass because entries at or above the count are never read
//  a request is taken in idle whenever the result register is empty or being
//    drained in the same cycle; a stalled result holds in that register
//
module nearest_vertex_search
  import nvs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  nvs_req_if.sink   in_req,
  nvs_rsp_if.source out_rsp
);

  // control state
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  rd_ptr_r;

  // query point, held for the whole scan
  vertex_t           qry_r;

  // running best
  logic [DIST_W-1:0] best_d_r;
  logic [ADDR_W-1:0] best_idx_r;
  vertex_t           best_pos_r;

  // result register
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [INDEX_W-1:0]  out_index_r;
  vertex_t             out_pos_r;
  logic [DIST_W-1:0]   out_dist_r;

  // comb control
  logic      slot_free;
  logic      req_take;
  logic      issue;
  logic      issue_last;
  logic      res_from_req;
  logic      res_from_best;
  scan_tag_t mem_tag_r;
  vertex_t   mem_rd_data;
  vertex_t   req_vtx;
  scan_tag_t dist_tag;
  vertex_t   dist_vtx;
  logic [DIST_W-1:0] dist_val;
  logic      best_upd;
  logic      store_full;
  logic      load_wr;

  assign slot_free  = !out_valid_r || out_rsp.ready;
  assign store_full = (count_r >= CNT_W'(MAX_VERTICES));
  assign req_vtx    = '{x: in_req.coord_x, y: in_req.coord_y, z: in_req.coord_z};
  assign issue_last = (rd_ptr_r == count_r - CNT_W'(1));
  assign load_wr    = req_take && (in_req.action == ACT_LOAD) && !store_full;

  // next state and strobes
  always_comb begin
    state_nxt     = state_r;
    in_req.ready  = 1'b0;
    req_take      = 1'b0;
    issue         = 1'b0;
    res_from_req  = 1'b0;
    res_from_best = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_req.ready = slot_free;
        req_take     = in_req.valid && slot_free;
        if (req_take) begin
          if (in_req.action == ACT_QUERY && count_r != '0) begin
            state_nxt = ST_SCAN;
          end else begin
            res_from_req = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        issue = 1'b1;
        if (issue_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (dist_tag.vld && dist_tag.last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          res_from_best = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // vertex count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (req_take && in_req.action == ACT_CLEAR) begin
      count_r <= '0;
    end else if (load_wr) begin
      count_r <= count_r + CNT_W'(1);
    end
  end

  // read pointer and query point
  always_ff @(posedge clk) begin
    if (req_take) begin
      rd_ptr_r <= '0;
      qry_r    <= req_vtx;
    end else if (issue) begin
      rd_ptr_r <= rd_ptr_r + CNT_W'(1);
    end
  end

  nvs_vertex_mem u_mem (
    .clk     (clk),
    .wr_en   (load_wr),
    .wr_addr (count_r[ADDR_W-1:0]),
    .wr_data (req_vtx),
    .rd_en   (issue),
    .rd_addr (rd_ptr_r[ADDR_W-1:0]),
    .rd_data (mem_rd_data)
  );

  // tag that lines up with the registered read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_tag_r.vld <= 1'b0;
    end else begin
      mem_tag_r.vld <= issue;
    end
    mem_tag_r.last <= issue_last;
    mem_tag_r.idx  <= rd_ptr_r[ADDR_W-1:0];
  end

  nvs_dist_unit u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .tag_in   (mem_tag_r),
    .vtx_in   (mem_rd_data),
    .qry      (qry_r),
    .tag_out  (dist_tag),
    .vtx_out  (dist_vtx),
    .dist_out (dist_val)
  );

  // first vertex always wins, later ones only when strictly closer
  assign best_upd = dist_tag.vld && (dist_tag.idx == '0 || dist_val < best_d_r);

  always_ff @(posedge clk) begin
    if (best_upd) begin
      best_d_r   <= dist_val;
      best_idx_r <= dist_tag.idx;
      best_pos_r <= dist_vtx;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_from_req || res_from_best) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_from_best) begin
      out_status_r <= STATUS_OK;
      out_index_r  <= to_index(best_idx_r);
      out_pos_r    <= best_pos_r;
      out_dist_r   <= best_d_r;
    end else if (res_from_req) begin
      out_index_r <= '0;
      out_pos_r   <= '0;
      out_dist_r  <= '0;
      if (in_req.action == ACT_LOAD && store_full) begin
        out_status_r <= STATUS_FULL;
      end else if (in_req.action == ACT_QUERY) begin
        out_status_r <= STATUS_EMPTY;
      end else begin
        out_status_r <= STATUS_OK;
      end
    end
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.status       = out_status_r;
  assign out_rsp.best_index   = out_index_r;
  assign out_rsp.best_x       = out_pos_r.x;
  assign out_rsp.best_y       = out_pos_r.y;
  assign out_rsp.best_z       = out_pos_r.z;
  assign out_rsp.best_dist_sq = out_dist_r;

  // count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_VERTICES))
    else $error("vertex count beyond store depth");

  // reads stay below the count during a scan
  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> rd_ptr_r < count_r)
    else $error("scan read past stored vertices");

  // a query on a non-empty store starts a scan
  a_query_scans: assert property (@(posedge clk) disable iff (!rst_n)
    req_take && in_req.action == ACT_QUERY && count_r != '0 |=> state_r == ST_SCAN)
    else $error("query did not start scan");

  // distance results appear only while a query is in flight
  a_dist_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    dist_tag.vld |-> (state_r == ST_SCAN || state_r == ST_DRAIN))
    else $error("distance result outside a scan");

  // a scan result is only built from a non-empty store
  a_done_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE |-> count_r != '0)
    else $error("scan finished on empty store");

endmodule
`default_nettype wire

// ----- hdl/nvs_vertex_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nvs_vertex_mem
// vertex store, one write port and one registered read port
// ----------------------------------------------------------------------------
module nvs_vertex_mem
  import nvs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire vertex_t           wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output vertex_t                rd_data
);

  vertex_t mem [MAX_VERTICES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/nvs_dist_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nvs_dist_unit
// three-stage squared distance: abs difference, square, sum
// ----------------------------------------------------------------------------
module nvs_dist_unit
  import nvs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire scan_tag_t tag_in,
  input  wire vertex_t   vtx_in,
  input  wire vertex_t   qry,
  output scan_tag_t      tag_out,
  output vertex_t        vtx_out,
  output logic [DIST_W-1:0] dist_out
);

  scan_tag_t tag1_r, tag2_r, tag3_r;
  vertex_t   vtx1_r, vtx2_r, vtx3_r;
  logic [ABS_W-1:0]  ax_r, ay_r, az_r;
  logic [SQ_W-1:0]   sx_r, sy_r, sz_r;
  logic [DIST_W-1:0] sum_r;

  function automatic logic [ABS_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                input logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    logic signed [COORD_W:0] m;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    m = d[COORD_W] ? -d : d;
    return m[ABS_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r.vld <= 1'b0;
      tag2_r.vld <= 1'b0;
      tag3_r.vld <= 1'b0;
    end else begin
      tag1_r.vld <= tag_in.vld;
      tag2_r.vld <= tag1_r.vld;
      tag3_r.vld <= tag2_r.vld;
    end
    tag1_r.last <= tag_in.last;
    tag1_r.idx  <= tag_in.idx;
    tag2_r.last <= tag1_r.last;
    tag2_r.idx  <= tag1_r.idx;
    tag3_r.last <= tag2_r.last;
    tag3_r.idx  <= tag2_r.idx;
    vtx1_r <= vtx_in;
    vtx2_r <= vtx1_r;
    vtx3_r <= vtx2_r;
    ax_r <= abs_diff(vtx_in.x, qry.x);
    ay_r <= abs_diff(vtx_in.y, qry.y);
    az_r <= abs_diff(vtx_in.z, qry.z);
    sx_r <= ax_r * ax_r;
    sy_r <= ay_r * ay_r;
    sz_r <= az_r * az_r;
    sum_r <= DIST_W'(sx_r) + DIST_W'(sy_r) + DIST_W'(sz_r);
  end

  assign tag_out  = tag3_r;
  assign vtx_out  = vtx3_r;
  assign dist_out = sum_r;

endmodule
`default_nettype wire

// ----- bench/nvs_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nvs_checker
// watches both channels of the nearest vertex search, keeps its own copy of
// the vertex store, works out the result of each accepted request and
// compares every accepted result, field by field, with the oldest one due
// ----------------------------------------------------------------------------
module nvs_checker
  import nvs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  nvs_req_if        req,
  nvs_rsp_if        rsp,
  output int        fail_count,
  output int        pending,
  output int        results_seen
);

  typedef struct {
    status_t            status;
    logic [INDEX_W-1:0] index;
    vertex_t            pos;
    logic [DIST_W-1:0]  dist_sq;
  } nearest_t;

  vertex_t     vertex_mem [MAX_VERTICES];
  int unsigned stored_n;
  nearest_t    nearest_q [$];

  function automatic longint unsigned sq_gap(logic signed [COORD_W-1:0] a,
                                             logic signed [COORD_W-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return longint'(d * d);
  endfunction

  // updates the store copy and returns the result this request must give
  function automatic nearest_t resolve_request(logic [ACTION_W-1:0] act, vertex_t pt);
    nearest_t          r;
    longint unsigned   d;
    longint unsigned   best_d;
    int unsigned       best;
    r.status  = STATUS_OK;
    r.index   = '0;
    r.pos     = '0;
    r.dist_sq = '0;
    best_d    = 0;
    best      = 0;
    case (act)
      ACT_LOAD: begin
        if (stored_n >= MAX_VERTICES) begin
          r.status = STATUS_FULL;
        end else begin
          vertex_mem[stored_n] = pt;
          stored_n++;
        end
      end
      ACT_CLEAR: begin
        stored_n = 0;
      end
      ACT_QUERY: begin
        if (stored_n == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          for (int unsigned i = 0; i < stored_n; i++) begin
            d = sq_gap(vertex_mem[i].x, pt.x) + sq_gap(vertex_mem[i].y, pt.y)
              + sq_gap(vertex_mem[i].z, pt.z);
            // strict compare: the lowest index wins a tie
            if (i == 0 || d < best_d) begin
              best_d = d;
              best   = i;
            end
          end
          r.index   = INDEX_W'(best);
          r.pos     = vertex_mem[best];
          r.dist_sq = DIST_W'(best_d);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
    $display("[%0t] result %0d: %s got 0x%0h, want 0x%0h", $time, results_seen, field,
             got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    nearest_t want;
    nearest_t due;
    if (!rst_n) begin
      stored_n = 0;
      nearest_q.delete();
      pending      <= 0;
      results_seen <= 0;
    end else begin
      // result side first: a result never belongs to a request taken at the same edge
      if (rsp.valid && rsp.ready) begin
        if (nearest_q.size() == 0) begin
          report_mismatch("result with no request outstanding, status", rsp.status, 0);
        end else begin
          want = nearest_q.pop_front();
          if (rsp.status !== want.status)
            report_mismatch("status", rsp.status, want.status);
          if (rsp.best_index !== want.index)
            report_mismatch("best_index", rsp.best_index, want.index);
          if (rsp.best_x !== want.pos.x)
            report_mismatch("best_x", 16'(rsp.best_x), 16'(want.pos.x));
          if (rsp.best_y !== want.pos.y)
            report_mismatch("best_y", 16'(rsp.best_y), 16'(want.pos.y));
          if (rsp.best_z !== want.pos.z)
            report_mismatch("best_z", 16'(rsp.best_z), 16'(want.pos.z));
          if (rsp.best_dist_sq !== want.dist_sq)
            report_mismatch("best_dist_sq", rsp.best_dist_sq, want.dist_sq);
        end
        results_seen <= results_seen + 1;
      end
      if (req.valid && req.ready) begin
        due = resolve_request(req.action, {req.coord_x, req.coord_y, req.coord_z});
        nearest_q = {nearest_q, due};
      end
      pending <= nearest_q.size();
    end
  end

endmodule

// ----- bench/nearest_vertex_search_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_vertex_search_tb
// drives load, clear, query and unused requests into the nearest vertex
// search with random gaps on both channels, and leaves prediction and
// comparison to the checker beside the block
// ----------------------------------------------------------------------------
module nearest_vertex_search_tb
  import nvs_pkg::*;
;

  // action code the block must accept and answer without any effect
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  localparam logic signed [COORD_W-1:0] C_MAX = 16'sh7FFF;
  localparam logic signed [COORD_W-1:0] C_MIN = 16'sh8000;

  localparam int N_RANDOM     = 520;
  localparam int RANDOM_DEPTH = 48;     // keeps random queries short
  localparam int FILL_DEPTH   = 24;     // loads before the closing queries
  localparam int HOLD_CYCLES  = 400;    // one long receiver stall
  localparam int HOLD_AFTER   = 60;     // results seen before that stall
  localparam int DRAIN_CYCLES = MAX_VERTICES + 16;
  localparam int LIMIT        = 1_000_000;

  logic clk;
  logic rst_n;
  int   cycle_count;
  int   fail_count;
  int   pending;
  int   results_seen;

  // top-side list of stored vertices, used only to aim queries and copies
  vertex_t placed [$];

  nvs_req_if req_ch ();
  nvs_rsp_if rsp_ch ();

  nearest_vertex_search u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  nvs_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // global watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // mostly no gap, some short, a few long, and now and then a stretch of none
  function automatic int draw_gap(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst = $urandom_range(20, 80);
      return 0;
    end
    if (r < 65) return 0;
    if (r < 94) return $urandom_range(1, 4);
    return $urandom_range(12, 60);
  endfunction

  function automatic vertex_t vtx(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                                  logic signed [COORD_W-1:0] z);
    vertex_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    return v;
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return C_MIN;
      1:       return C_MAX;
      2:       return '0;
      3:       return -16'sd1;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic vertex_t rand_point();
    return vtx(rand_coord(), rand_coord(), rand_coord());
  endfunction

  // a stored vertex copied for ties, else a fresh point
  function automatic vertex_t load_point();
    if (placed.size() != 0 && $urandom_range(0, 4) == 0)
      return placed[$urandom_range(0, placed.size() - 1)];
    return rand_point();
  endfunction

  // query point: on a stored vertex, just beside one, or anywhere
  function automatic vertex_t aim_point();
    vertex_t v;
    if (placed.size() == 0 || $urandom_range(0, 1) == 0) return rand_point();
    v = placed[$urandom_range(0, placed.size() - 1)];
    if ($urandom_range(0, 1) == 0) begin
      v.x = v.x + COORD_W'($urandom_range(0, 8)) - 16'sd4;
      v.y = v.y + COORD_W'($urandom_range(0, 8)) - 16'sd4;
      v.z = v.z + COORD_W'($urandom_range(0, 8)) - 16'sd4;
    end
    return v;
  endfunction

  // offer one request, wait for it to be taken, then maybe idle
  task automatic send_req(logic [ACTION_W-1:0] act, vertex_t p, inout int burst);
    int gap;
    req_ch.valid   <= 1'b1;
    req_ch.action  <= act;
    req_ch.coord_x <= p.x;
    req_ch.coord_y <= p.y;
    req_ch.coord_z <= p.z;
    do @(posedge clk); while (!req_ch.ready);
    case (act)
      ACT_LOAD:  if (placed.size() < MAX_VERTICES) placed = {placed, p};
      ACT_CLEAR: placed.delete();
      default:   ;
    endcase
    gap = draw_gap(burst);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // receiver: random ready, with one long hold while the sender keeps going
  initial begin
    int  gap;
    int  burst;
    bit  held;
    burst = 0;
    held  = 1'b0;
    rsp_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = draw_gap(burst);
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // sender and verdict
  initial begin
    int burst;
    int r;
    burst       = 0;
    cycle_count <= 0;
    rst_n          <= 1'b0;
    req_ch.valid   <= 1'b0;
    req_ch.action  <= ACT_LOAD;
    req_ch.coord_x <= '0;
    req_ch.coord_y <= '0;
    req_ch.coord_z <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty store, extremes, exact hits, ties, unused code, clear
    send_req(ACT_QUERY, vtx(C_MIN, C_MAX, 16'sd0), burst);
    send_req(ACT_LOAD, vtx(C_MAX, C_MAX, C_MAX), burst);
    send_req(ACT_QUERY, vtx(C_MIN, C_MIN, C_MIN), burst);  // largest distance
    send_req(ACT_LOAD, vtx(C_MIN, C_MIN, C_MIN), burst);
    send_req(ACT_LOAD, vtx(16'sd0, 16'sd0, 16'sd0), burst);
    send_req(ACT_LOAD, vtx(16'sd0, 16'sd0, 16'sd0), burst);  // duplicate
    send_req(ACT_QUERY, vtx(C_MAX, C_MAX, C_MAX), burst);
    send_req(ACT_QUERY, vtx(C_MIN, C_MIN, C_MIN), burst);
    send_req(ACT_QUERY, vtx(16'sd0, 16'sd0, 16'sd0), burst);  // tie, lower index
    send_req(ACT_QUERY, vtx(C_MAX, C_MIN, -16'sd1), burst);
    send_req(ACT_UNUSED, vtx(C_MIN, C_MAX, -16'sd1), burst);
    send_req(ACT_QUERY, vtx(16'sd1, -16'sd1, 16'sd256), burst);
    send_req(ACT_CLEAR, vtx(C_MAX, C_MIN, C_MAX), burst);
    send_req(ACT_QUERY, vtx(16'sd0, 16'sd0, 16'sd0), burst);  // empty after clear
    send_req(ACT_LOAD, vtx(16'sd256, 16'sd0, 16'sd0), burst);
    send_req(ACT_LOAD, vtx(-16'sd256, 16'sd0, 16'sd0), burst);
    send_req(ACT_LOAD, vtx(16'sd0, 16'sd256, 16'sd0), burst);
    send_req(ACT_QUERY, vtx(16'sd0, 16'sd0, 16'sd0), burst);  // three-way tie
    send_req(ACT_QUERY, vtx(-16'sd200, 16'sd0, 16'sd0), burst);
    send_req(ACT_QUERY, vtx(16'sd0, 16'sd255, -16'sd1), burst);
    send_req(ACT_CLEAR, vtx(16'sd0, 16'sd0, 16'sd0), burst);

    // hold off until every result is back
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    @(posedge clk);

    // random mix with a store kept shallow so queries stay short
    for (int k = 0; k < N_RANDOM; k++) begin
      r = $urandom_range(0, 99);
      if (r < 45 && placed.size() < RANDOM_DEPTH)
        send_req(ACT_LOAD, load_point(), burst);
      else if (r < 88)
        send_req(ACT_QUERY, aim_point(), burst);
      else if (r < 96)
        send_req(ACT_CLEAR, rand_point(), burst);
      else
        send_req(ACT_UNUSED, rand_point(), burst);
    end

    // a fresh store, queries on it, a load, then clear, an empty query, and one more load and query
    send_req(ACT_CLEAR, rand_point(), burst);
    for (int k = 0; k < FILL_DEPTH; k++)
      send_req(ACT_LOAD, load_point(), burst);
    send_req(ACT_QUERY, aim_point(), burst);
    send_req(ACT_QUERY, placed[placed.size() - 1], burst);
    send_req(ACT_QUERY, rand_point(), burst);
    send_req(ACT_LOAD, rand_point(), burst);
    send_req(ACT_CLEAR, rand_point(), burst);
    send_req(ACT_QUERY, rand_point(), burst);
    send_req(ACT_LOAD, rand_point(), burst);
    send_req(ACT_QUERY, aim_point(), burst);

    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/nvs_pkg.sv
hdl/nvs_req_if.sv
hdl/nvs_rsp_if.sv
hdl/nvs_vertex_mem.sv
hdl/nvs_dist_unit.sv
hdl/nearest_vertex_search.sv
bench/nvs_checker.sv
bench/nearest_vertex_search_tb.sv
